// File: rtl/assert_macros.svh
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/cst_pkg.sv
// Package of types, constants and character classes for the source tokenizer.
`timescale 1ns / 1ps
package cst_pkg;
    localparam int SOURCE_BYTES_MAX_DEF = 65536;
    localparam int IDENT_BYTES_MAX_DEF  = 63;
    localparam int OFS_W = 17;

    // Token kinds.
    localparam logic [2:0] K_IDENT = 3'd0;
    localparam logic [2:0] K_NUM   = 3'd1;
    localparam logic [2:0] K_STR   = 3'd2;
    localparam logic [2:0] K_OP    = 3'd3;
    localparam logic [2:0] K_END   = 3'd4;
    localparam logic [2:0] K_ERR   = 3'd5;

    // Error codes.
    localparam logic [3:0] E_NONE    = 4'd0;
    localparam logic [3:0] E_COMMENT = 4'd1;
    localparam logic [3:0] E_LONG    = 4'd2;
    localparam logic [3:0] E_OCTAL   = 4'd3;
    localparam logic [3:0] E_OVF     = 4'd4;
    localparam logic [3:0] E_BADINT  = 4'd5;
    localparam logic [3:0] E_BADLIT  = 4'd6;
    localparam logic [3:0] E_ESCEND  = 4'd7;
    localparam logic [3:0] E_HEXESC  = 4'd8;
    localparam logic [3:0] E_ESC     = 4'd9;
    localparam logic [3:0] E_NONPRT  = 4'd10;
    localparam logic [3:0] E_CHAR    = 4'd11;

    // Lexer modes.
    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_SLASH = 4'd1;
    localparam logic [3:0] M_LINE  = 4'd2;
    localparam logic [3:0] M_BLOCK = 4'd3;
    localparam logic [3:0] M_BSTAR = 4'd4;
    localparam logic [3:0] M_IDENT = 4'd5;
    localparam logic [3:0] M_ZERO  = 4'd6;
    localparam logic [3:0] M_DEC   = 4'd7;
    localparam logic [3:0] M_HEXF  = 4'd8;
    localparam logic [3:0] M_HEX   = 4'd9;
    localparam logic [3:0] M_OP    = 4'd10;
    localparam logic [3:0] M_LIT   = 4'd11;
    localparam logic [3:0] M_ESC   = 4'd12;
    localparam logic [3:0] M_HEX1  = 4'd13;
    localparam logic [3:0] M_HEX2  = 4'd14;

    // One result token.
    typedef struct packed {
        logic [2:0]       kind;
        logic [63:0]      value;
        logic [7:0]       op_a;
        logic [7:0]       op_b;
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] len;
        logic [3:0]       err;
    } t_tok;

    // Result pair of one transaction.
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       t0;
        t_tok       t1;
    } t_res;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        case (c)
            "{", "}", "(", ")", ";", ",", "+", "-", "*", "/", "%", "&", "|", "^",
            "~", "!", "=", "<", ">": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_assign(input logic [7:0] c);
        case (c)
            "=", "!", "<", ">", "+", "-", "*", "/", "%", "&", "|", "^": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_double(input logic [7:0] c);
        case (c)
            "<", ">", "&", "|", "+", "-": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Hex digit value; bit 4 set means not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd16;
        if (c >= "0" && c <= "9") t = c - 8'd48;
        else if (c >= "a" && c <= "f") t = c - 8'd87;
        else if (c >= "A" && c <= "F") t = c - 8'd55;
        return t[4:0];
    endfunction
endpackage

// File: rtl/cst_lex.sv
// Lexer state and single-pass per-byte token logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cst_lex #(
    parameter int SOURCE_BYTES_MAX = cst_pkg::SOURCE_BYTES_MAX_DEF,
    parameter int IDENT_BYTES_MAX  = cst_pkg::IDENT_BYTES_MAX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [7:0]     i_byte,
    input  logic           i_end,
    output cst_pkg::t_res  o_res
);
    localparam int OW = cst_pkg::OFS_W;
    localparam int CW = $clog2(SOURCE_BYTES_MAX + 1);

    logic [3:0]    r_mode, n_mode;
    logic [63:0]   r_acc, n_acc;
    logic [7:0]    r_lbyte, n_lbyte;
    logic [1:0]    r_lcnt, n_lcnt;
    logic [3:0]    r_hexh, n_hexh;
    logic [7:0]    r_pop, n_pop;
    logic          r_dq, n_dq;
    logic [OW-1:0] r_tstart, n_tstart;
    logic [CW-1:0] r_ofs, n_ofs;
    logic          r_fail, n_fail;
    cst_pkg::t_res res;

    logic [OW-1:0] ofs, len;
    logic [4:0]    h;
    logic [63:0]   acc10, acc16;
    logic [67:0]   sum10;
    logic          ovf10, ovf16;

    assign ofs = OW'(r_ofs);
    assign len = ofs - r_tstart;
    assign h   = cst_pkg::hex_val(i_byte);
    // Decimal and hex step with exact overflow detection.
    assign sum10 = {4'd0, r_acc} * 68'd10 + {64'd0, i_byte[3:0]};
    assign ovf10 = |sum10[67:64];
    assign acc10 = sum10[63:0];
    assign ovf16 = |r_acc[63:60];
    assign acc16 = {r_acc[59:0], h[3:0]};

    function automatic cst_pkg::t_tok mk(input logic [2:0] k, input logic [63:0] v,
                                         input logic [7:0] a, input logic [7:0] b,
                                         input logic [OW-1:0] s, input logic [OW-1:0] l,
                                         input logic [3:0] e);
        cst_pkg::t_tok t;
        t.kind = k; t.value = v; t.op_a = a; t.op_b = b; t.start = s; t.len = l; t.err = e;
        return t;
    endfunction

    // Per-byte and end-marker update.
    always_comb begin
        cst_pkg::t_tok pt;
        logic          pv;
        logic          st;
        logic          ch;
        logic [7:0]    chv;
        logic [7:0]    c;
        logic          fl;
        logic [3:0]    fc;
        c = i_byte;
        n_mode = r_mode; n_acc = r_acc; n_lbyte = r_lbyte; n_lcnt = r_lcnt;
        n_hexh = r_hexh; n_pop = r_pop; n_dq = r_dq; n_tstart = r_tstart;
        n_ofs = r_ofs; n_fail = r_fail;
        pt = '0; pv = 1'b0; st = 1'b0; ch = 1'b0; chv = c; fl = 1'b0; fc = cst_pkg::E_NONE;
        res = '0;
        if (i_end) begin
            if (!r_fail) begin
                case (r_mode)
                    cst_pkg::M_SLASH: begin
                        pv = 1'b1; pt = mk(cst_pkg::K_OP, 64'd0, "/", 8'd0, r_tstart, 17'd1,
                                           cst_pkg::E_NONE);
                    end
                    cst_pkg::M_BLOCK, cst_pkg::M_BSTAR: begin fl = 1'b1; fc = cst_pkg::E_COMMENT; end
                    cst_pkg::M_IDENT: begin
                        pv = 1'b1; pt = mk(cst_pkg::K_IDENT, 64'd0, 8'd0, 8'd0, r_tstart, len,
                                           cst_pkg::E_NONE);
                    end
                    cst_pkg::M_ZERO, cst_pkg::M_DEC, cst_pkg::M_HEX: begin
                        pv = 1'b1; pt = mk(cst_pkg::K_NUM, r_acc, 8'd0, 8'd0, r_tstart, len,
                                           cst_pkg::E_NONE);
                    end
                    cst_pkg::M_HEXF: begin fl = 1'b1; fc = cst_pkg::E_BADINT; end
                    cst_pkg::M_OP: begin
                        pv = 1'b1; pt = mk(cst_pkg::K_OP, 64'd0, r_pop, 8'd0, r_tstart, 17'd1,
                                           cst_pkg::E_NONE);
                    end
                    cst_pkg::M_LIT: begin fl = 1'b1; fc = cst_pkg::E_BADLIT; end
                    cst_pkg::M_ESC: begin fl = 1'b1; fc = cst_pkg::E_ESCEND; end
                    cst_pkg::M_HEX1, cst_pkg::M_HEX2: begin fl = 1'b1; fc = cst_pkg::E_HEXESC; end
                    default: ;
                endcase
            end
            if (fl) begin
                pv = 1'b1; pt = mk(cst_pkg::K_ERR, 64'd0, 8'd0, 8'd0, r_tstart, 17'd0, fc);
            end
            res.cnt = pv ? 2'd2 : 2'd1;
            res.t0 = pv ? pt : mk(cst_pkg::K_END, 64'd0, 8'd0, 8'd0, ofs, 17'd0, cst_pkg::E_NONE);
            res.t1 = mk(cst_pkg::K_END, 64'd0, 8'd0, 8'd0, ofs, 17'd0, cst_pkg::E_NONE);
            n_mode = cst_pkg::M_IDLE; n_acc = '0; n_lbyte = '0; n_lcnt = '0; n_hexh = '0;
            n_pop = '0; n_dq = 1'b0; n_tstart = '0; n_ofs = '0; n_fail = 1'b0;
        end else if (r_ofs < CW'(SOURCE_BYTES_MAX)) begin
            n_ofs = r_ofs + 1'b1;
            if (!r_fail) begin
                case (r_mode)
                    cst_pkg::M_SLASH: begin
                        if (c == "/") n_mode = cst_pkg::M_LINE;
                        else if (c == "*") n_mode = cst_pkg::M_BLOCK;
                        else if (c == "=") begin
                            pv = 1'b1; n_mode = cst_pkg::M_IDLE;
                            pt = mk(cst_pkg::K_OP, 64'd0, "/", "=", r_tstart, 17'd2,
                                    cst_pkg::E_NONE);
                        end else begin
                            pv = 1'b1; st = 1'b1;
                            pt = mk(cst_pkg::K_OP, 64'd0, "/", 8'd0, r_tstart, 17'd1,
                                    cst_pkg::E_NONE);
                        end
                    end
                    cst_pkg::M_LINE: if (c == 8'h0a || c == 8'h0d) n_mode = cst_pkg::M_IDLE;
                    cst_pkg::M_BLOCK: if (c == "*") n_mode = cst_pkg::M_BSTAR;
                    cst_pkg::M_BSTAR: begin
                        if (c == "/") n_mode = cst_pkg::M_IDLE;
                        else if (c != "*") n_mode = cst_pkg::M_BLOCK;
                    end
                    cst_pkg::M_IDENT: begin
                        if (cst_pkg::is_alpha(c) || cst_pkg::is_digit(c)) begin
                            if ({1'b0, len} + 18'd1 > 18'(IDENT_BYTES_MAX)) begin
                                fl = 1'b1; fc = cst_pkg::E_LONG;
                            end
                        end else begin
                            pv = 1'b1; st = 1'b1;
                            pt = mk(cst_pkg::K_IDENT, 64'd0, 8'd0, 8'd0, r_tstart, len,
                                    cst_pkg::E_NONE);
                        end
                    end
                    cst_pkg::M_ZERO: begin
                        if (c == "x" || c == "X") n_mode = cst_pkg::M_HEXF;
                        else if (cst_pkg::is_digit(c)) begin fl = 1'b1; fc = cst_pkg::E_OCTAL; end
                        else if (cst_pkg::is_alpha(c)) begin fl = 1'b1; fc = cst_pkg::E_BADINT; end
                        else begin
                            pv = 1'b1; st = 1'b1;
                            pt = mk(cst_pkg::K_NUM, 64'd0, 8'd0, 8'd0, r_tstart, len,
                                    cst_pkg::E_NONE);
                        end
                    end
                    cst_pkg::M_DEC: begin
                        if (cst_pkg::is_digit(c)) begin
                            if (ovf10) begin fl = 1'b1; fc = cst_pkg::E_OVF; end
                            else n_acc = acc10;
                        end else if (cst_pkg::is_alpha(c)) begin
                            fl = 1'b1; fc = cst_pkg::E_BADINT;
                        end else begin
                            pv = 1'b1; st = 1'b1;
                            pt = mk(cst_pkg::K_NUM, r_acc, 8'd0, 8'd0, r_tstart, len,
                                    cst_pkg::E_NONE);
                        end
                    end
                    cst_pkg::M_HEXF, cst_pkg::M_HEX: begin
                        if (!h[4]) begin
                            if (ovf16) begin fl = 1'b1; fc = cst_pkg::E_OVF; end
                            else begin n_acc = acc16; n_mode = cst_pkg::M_HEX; end
                        end else if (r_mode == cst_pkg::M_HEXF || cst_pkg::is_alpha(c)
                                     || cst_pkg::is_digit(c)) begin
                            fl = 1'b1; fc = cst_pkg::E_BADINT;
                        end else begin
                            pv = 1'b1; st = 1'b1;
                            pt = mk(cst_pkg::K_NUM, r_acc, 8'd0, 8'd0, r_tstart, len,
                                    cst_pkg::E_NONE);
                        end
                    end
                    cst_pkg::M_OP: begin
                        pv = 1'b1;
                        if ((c == "=" && cst_pkg::is_assign(r_pop)) ||
                            (c == r_pop && cst_pkg::is_double(r_pop))) begin
                            n_mode = cst_pkg::M_IDLE;
                            pt = mk(cst_pkg::K_OP, 64'd0, r_pop, c, r_tstart, 17'd2,
                                    cst_pkg::E_NONE);
                        end else begin
                            st = 1'b1;
                            pt = mk(cst_pkg::K_OP, 64'd0, r_pop, 8'd0, r_tstart, 17'd1,
                                    cst_pkg::E_NONE);
                        end
                    end
                    cst_pkg::M_LIT: begin
                        if (c == (r_dq ? 8'h22 : 8'h27)) begin
                            if (!r_dq && r_lcnt != 2'd1) begin fl = 1'b1; fc = cst_pkg::E_BADLIT; end
                            else begin
                                pv = 1'b1; n_mode = cst_pkg::M_IDLE;
                                pt = mk(r_dq ? cst_pkg::K_STR : cst_pkg::K_NUM,
                                        {56'd0, r_lbyte}, 8'd0, 8'd0, r_tstart, len + 17'd1,
                                        cst_pkg::E_NONE);
                            end
                        end else if (c == 8'h5c) n_mode = cst_pkg::M_ESC;
                        else if (c < 8'd32 || c > 8'd126) begin fl = 1'b1; fc = cst_pkg::E_NONPRT; end
                        else ch = 1'b1;
                    end
                    cst_pkg::M_ESC: begin
                        n_mode = cst_pkg::M_LIT;
                        case (c)
                            "n": begin ch = 1'b1; chv = 8'h0a; end
                            "r": begin ch = 1'b1; chv = 8'h0d; end
                            "t": begin ch = 1'b1; chv = 8'h09; end
                            "0": begin ch = 1'b1; chv = 8'h00; end
                            "x": n_mode = cst_pkg::M_HEX1;
                            8'h5c, 8'h22, 8'h27: ch = 1'b1;
                            default: begin fl = 1'b1; fc = cst_pkg::E_ESC; end
                        endcase
                    end
                    cst_pkg::M_HEX1: begin
                        if (!h[4]) begin n_hexh = h[3:0]; n_mode = cst_pkg::M_HEX2; end
                        else begin fl = 1'b1; fc = cst_pkg::E_HEXESC; end
                    end
                    cst_pkg::M_HEX2: begin
                        if (!h[4]) begin
                            ch = 1'b1; chv = {r_hexh, h[3:0]}; n_mode = cst_pkg::M_LIT;
                        end else begin fl = 1'b1; fc = cst_pkg::E_HEXESC; end
                    end
                    default: st = 1'b1;
                endcase
                if (ch) begin
                    n_lbyte = chv;
                    if (r_lcnt < 2'd2) n_lcnt = r_lcnt + 2'd1;
                end
                // Start of a new token from idle or after the previous one closed.
                if (st) begin
                    cst_pkg::t_tok t2;
                    logic v2;
                    t2 = '0; v2 = 1'b0;
                    n_mode = cst_pkg::M_IDLE;
                    if (!(c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a)) begin
                        n_tstart = ofs;
                        if (c == "/") begin n_mode = cst_pkg::M_SLASH; n_pop = c; end
                        else if (cst_pkg::is_alpha(c)) n_mode = cst_pkg::M_IDENT;
                        else if (c == "0") begin n_mode = cst_pkg::M_ZERO; n_acc = '0; end
                        else if (cst_pkg::is_digit(c)) begin
                            n_mode = cst_pkg::M_DEC; n_acc = {60'd0, c[3:0]};
                        end else if (c == 8'h27 || c == 8'h22) begin
                            n_mode = cst_pkg::M_LIT; n_dq = (c == 8'h22);
                            n_lcnt = '0; n_lbyte = '0;
                        end else if (cst_pkg::is_op(c)) begin
                            if (cst_pkg::is_assign(c)) begin n_mode = cst_pkg::M_OP; n_pop = c; end
                            else begin
                                v2 = 1'b1;
                                t2 = mk(cst_pkg::K_OP, 64'd0, c, 8'd0, ofs, 17'd1,
                                        cst_pkg::E_NONE);
                            end
                        end else begin
                            v2 = 1'b1; n_fail = 1'b1;
                            t2 = mk(cst_pkg::K_ERR, 64'd0, 8'd0, 8'd0, ofs, 17'd0,
                                    cst_pkg::E_CHAR);
                        end
                    end
                    if (v2) begin
                        if (pv) begin res.t1 = t2; res.cnt = 2'd2; end
                        else begin pt = t2; pv = 1'b1; end
                    end
                end
                if (fl) begin
                    pv = 1'b1; n_fail = 1'b1; n_mode = cst_pkg::M_IDLE;
                    pt = mk(cst_pkg::K_ERR, 64'd0, 8'd0, 8'd0, r_tstart, 17'd0, fc);
                end
                res.t0 = pt;
                if (pv && res.cnt == 2'd0) res.cnt = 2'd1;
            end
        end
        o_res = res;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cst_pkg::M_IDLE; r_acc <= '0; r_lbyte <= '0; r_lcnt <= '0;
            r_hexh <= '0; r_pop <= '0; r_dq <= 1'b0; r_tstart <= '0; r_ofs <= '0;
            r_fail <= 1'b0;
        end else if (i_en) begin
            r_mode <= n_mode; r_acc <= n_acc; r_lbyte <= n_lbyte; r_lcnt <= n_lcnt;
            r_hexh <= n_hexh; r_pop <= n_pop; r_dq <= n_dq; r_tstart <= n_tstart;
            r_ofs <= n_ofs; r_fail <= n_fail;
        end
    end

    `ASSERT_IMPL(a_fail_idle, i_clk, i_rst_n, r_fail, r_mode == cst_pkg::M_IDLE)
    `ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_en && i_end, r_ofs == '0 && !r_fail)
    `ASSERT_IMPL(a_ofs_limit, i_clk, i_rst_n, 1'b1, r_ofs <= CW'(SOURCE_BYTES_MAX))
endmodule

// File: rtl/cst_out.sv
// Result buffer that delivers up to two tokens per transaction.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cst_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  cst_pkg::t_res  i_res,
    output logic           o_free,
    output logic           o_valid,
    output cst_pkg::t_tok  o_tok,
    output logic           o_last,
    input  logic           i_ready
);
    logic [1:0]    r_cnt;
    cst_pkg::t_tok r_t0, r_t1;
    logic          pop;

    assign o_valid = r_cnt != 2'd0;
    assign o_tok   = r_t0;
    assign o_last  = r_cnt == 2'd1;
    assign pop     = o_valid && i_ready;
    // Room for a new pair once the last held token leaves.
    assign o_free  = r_cnt == 2'd0 || (r_cnt == 2'd1 && i_ready);

    // Two-entry shift buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_res.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_t0 <= i_res.t0;
            r_t1 <= i_res.t1;
        end else if (pop) begin
            r_t0 <= r_t1;
        end
    end

    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, i_load, o_free)
endmodule

// File: rtl/c_style_source_tokenizer.sv
// Top level of the C-style source tokenizer.
`timescale 1ns / 1ps
// Scans source text at one byte per clock while the buffer has room. Each byte is lexed in
// the same cycle it is accepted, and its tokens (none, one or two) land in a two-entry result
// buffer; the next byte is taken as soon as the buffer can accept the new pair. The end
// marker flushes any pending token and gives the end token.
module c_style_source_tokenizer #(
    parameter int SOURCE_BYTES_MAX = cst_pkg::SOURCE_BYTES_MAX_DEF,
    parameter int IDENT_BYTES_MAX  = cst_pkg::IDENT_BYTES_MAX_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // source_byte
    input  logic         s_axis_tlast,   // end_of_source
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // token_value, operator_first, operator_second, start_offset, token_length,
    // error_code, zero fill
    output logic [119:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // token_kind
    output logic         m_axis_tlast    // last_of_run
);
    cst_pkg::t_res res;
    cst_pkg::t_tok tok;
    logic          free, load;

    assign s_axis_tready = free;
    assign load = s_axis_tvalid && free;

    cst_lex #(.SOURCE_BYTES_MAX(SOURCE_BYTES_MAX), .IDENT_BYTES_MAX(IDENT_BYTES_MAX)) u_lex (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(load), .i_byte(s_axis_tdata),
        .i_end(s_axis_tlast), .o_res(res)
    );

    cst_out u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(load), .i_res(res), .o_free(free),
        .o_valid(m_axis_tvalid), .o_tok(tok), .o_last(m_axis_tlast), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {2'd0, tok.err, tok.len, tok.start, tok.op_b, tok.op_a, tok.value};
    assign m_axis_tuser = tok.kind;
endmodule
